FILE: hw/rtl/ihe_pkg.sv
`default_nettype none
package ihe_pkg;

  typedef struct packed {
    logic [7:0] chan_blue;
    logic [7:0] chan_green;
    logic [7:0] chan_red;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [19:0] entropy_value;
    logic        count_overflow;
    logic        done_res;
  } res_t;

  // gray conversion weights, q14
  localparam logic [13:0] WeightB = 14'd1868;
  localparam logic [13:0] WeightG = 14'd9617;
  localparam logic [13:0] WeightR = 14'd4899;
  localparam logic [14:0] GrayRnd = 15'd8192;
  localparam logic [23:0] EpsQ24  = 24'd1678;
  localparam logic [23:0] Ln2Q24  = 24'd11629080;
  localparam int unsigned BinCount = 256;
  localparam int unsigned BinBits  = 8;

endpackage
`default_nettype wire

FILE: hw/rtl/ihe_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module ihe_div #(
  parameter int unsigned NumBits = 56,
  parameter int unsigned DenBits = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DenBits-1:0] den_i,
  output logic                    busy_o,
  output logic [NumBits-1:0]      quo_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenBits-1:0], quo_q[NumBits-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/image_histogram_entropy_top.sv
`default_nettype none
// image histogram entropy
// pixel channel (pix_valid_i/pix_ready_o, pix_i) carries b, g, r and a last flag;
// result channel (res_valid_o/res_ready_i, res_o) carries one entropy per image;
// config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes color_mode.
// a pixel in color mode steps through idle, gray weighting on the shared
// multiplier (three passes), bin read with the request taken, then the write
// back; with color mode off the weighting is skipped.
// the last pixel starts the entropy pass; for each bin: bin read and clear,
// divide (one quotient bit a cycle), log setup, 24-step squaring log (one
// multiply a step), accumulate; after all 256 bins, ln2 scale and rounding.
// the same bin sweep writes zero back, so the histogram is clear when done.
// reset: a clearing pass writes zero into all 256 bins of the bin memory; pixels
// are not taken until it ends, config requests are taken at any time.
// the result sits in an output register; while the receiver stalls the block
// holds the result and takes no pixel until it is taken.
module image_histogram_entropy_top #(
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pix_valid_i,
  output logic               pix_ready_o,
  input  wire ihe_pkg::pix_t pix_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output ihe_pkg::res_t      res_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic          cfg_data_i
);
  localparam int unsigned BB   = ihe_pkg::BinBits;
  localparam int unsigned NumW = COUNT_BITS + 24;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_RD, S_WR, S_BRA, S_BRD, S_DIV, S_LOGE, S_SQ, S_ACC,
    S_FIN, S_SCALE, S_OUT
  } state_e;

  state_e state_q;
  logic [BB-1:0] idx_q;
  logic [1:0]    ch_q;
  logic [21:0]   gacc_q;
  logic [BB-1:0] gray_q;
  logic          last_q;
  logic          mode_q;
  logic [COUNT_BITS-1:0] total_q;
  logic          ovf_q;
  logic [4:0]    step_q;
  logic [5:0]    ee_q;
  logic [31:0]   m_q;
  logic [23:0]   frac_q;
  logic [29:0]   qv_q;
  logic signed [63:0] s_q;
  logic [19:0]   res_val_q;
  logic          res_ovf_q;
  logic          res_v_q;

  // bin memory
  logic [COUNT_BITS-1:0] mem [ihe_pkg::BinCount];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  we;
  logic [BB-1:0]         waddr, raddr;
  logic [COUNT_BITS-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // L = (e - 24) * 2^24 + frac is signed: the multiplier takes its magnitude
  // and the sign picks add or subtract in the accumulate step
  logic [29:0] lval, lmag;
  logic        lneg;
  assign lval = {ee_q, frac_q} - {6'd24, 24'd0};
  assign lneg = lval[29];
  assign lmag = lneg ? (30'd0 - lval) : lval;

  // shared multiplier, 32x32
  logic [31:0] ma, mb;
  logic [63:0] mp;
  assign mp = ma * mb;

  always_comb begin
    ma = m_q;
    mb = m_q;
    unique case (state_q)
      S_MUL: begin
        unique case (ch_q)
          2'd0: begin ma = 32'(pix_i.chan_blue);  mb = 32'(ihe_pkg::WeightB); end
          2'd1: begin ma = 32'(pix_i.chan_green); mb = 32'(ihe_pkg::WeightG); end
          default: begin ma = 32'(pix_i.chan_red); mb = 32'(ihe_pkg::WeightR); end
        endcase
      end
      S_ACC:   begin ma = 32'(qv_q); mb = 32'(lmag); end
      S_SCALE: begin ma = 32'(s_q[31:0]); mb = 32'(ihe_pkg::Ln2Q24); end
      default: ;
    endcase
  end

  // divider
  logic            div_start, div_busy;
  logic [NumW-1:0] div_q;
  ihe_div #(.NumBits(NumW), .DenBits(COUNT_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i({rd_q, 24'd0} + NumW'(total_q >> 1)),
    .den_i(total_q),
    .busy_o(div_busy),
    .quo_o(div_q)
  );

  logic [29:0] qsum;
  assign qsum = div_q[29:0] + 30'(ihe_pkg::EpsQ24);

  // highest set bit of q
  logic [4:0] hb;
  always_comb begin
    hb = '0;
    for (int k = 0; k < 30; k++) if (qv_q[k]) hb = 5'(k);
  end

  logic [21:0] gray_sum;
  assign gray_sum = gacc_q + 22'(ihe_pkg::GrayRnd);
  logic [BB-1:0] gray_now;
  assign gray_now = mode_q ? gray_sum[14+BB-1:14] : pix_i.chan_blue;
  logic full;
  assign full = (total_q == {COUNT_BITS{1'b1}});

  // rounding of the final scale
  localparam logic [63:0] RndF = 64'd1 << (47 - FRAC_BITS);
  localparam logic [63:0] Lim  = (64'd1 << (FRAC_BITS + 4)) - 64'd1;
  logic [63:0] s24, rsc;
  assign s24 = (s_q < 0) ? 64'd0 : ((64'(s_q) + 64'h80_0000) >> 24);
  assign rsc = (mp + RndF) >> (48 - FRAC_BITS);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = '0;
    raddr = idx_q;
    div_start = 1'b0;
    unique case (state_q) inside
      S_CLR: we = 1'b1;
      S_IDLE, S_MUL, S_RD: raddr = gray_now;
      S_WR: begin
        raddr = gray_q;
        waddr = gray_q;
        wdata = rd_q + 1'b1;
        we    = !full;
      end
      S_BRD: begin
        div_start = 1'b1;
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      idx_q     <= '0;
      ch_q      <= '0;
      gacc_q    <= '0;
      gray_q    <= '0;
      last_q    <= 1'b0;
      mode_q    <= 1'b1;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      res_v_q   <= 1'b0;
      step_q    <= '0;
      ee_q      <= '0;
      m_q       <= '0;
      frac_q    <= '0;
      qv_q      <= '0;
      s_q       <= '0;
      res_val_q <= '0;
      res_ovf_q <= 1'b0;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      unique case (state_q)
        S_CLR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: if (pix_valid_i) begin
          ch_q    <= '0;
          gacc_q  <= '0;
          state_q <= mode_q ? S_MUL : S_RD;
        end
        S_MUL: begin
          gacc_q <= gacc_q + mp[21:0];
          ch_q   <= ch_q + 1'b1;
          if (ch_q == 2'd2) state_q <= S_RD;
        end
        S_RD: begin
          gray_q  <= gray_now;
          last_q  <= pix_i.last_pixel;
          state_q <= S_WR;
        end
        S_WR: begin
          if (full) ovf_q <= 1'b1;
          else total_q <= total_q + 1'b1;
          idx_q   <= '0;
          s_q     <= '0;
          state_q <= last_q ? S_BRA : S_IDLE;
        end
        // bin address is presented here, the count is in rd_q next cycle
        S_BRA: state_q <= S_BRD;
        S_BRD: state_q <= S_DIV;
        S_DIV: if (!div_busy) begin
          qv_q    <= qsum;
          state_q <= S_LOGE;
        end
        S_LOGE: begin
          ee_q    <= 6'(hb);
          m_q     <= 32'(qv_q) << (5'd30 - hb);
          frac_q  <= '0;
          step_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (mp[63:30] >= 34'h8000_0000) begin
            m_q <= mp[62:31];
            frac_q[5'd23 - step_q] <= 1'b1;
          end else begin
            m_q <= mp[61:30];
          end
          step_q <= step_q + 1'b1;
          if (step_q == 5'd23) state_q <= S_ACC;
        end
        S_ACC: begin
          s_q   <= lneg ? (s_q + $signed(mp)) : (s_q - $signed(mp));
          idx_q <= idx_q + 1'b1;
          state_q <= (idx_q == '1) ? S_FIN : S_BRA;
        end
        S_FIN: begin
          s_q     <= $signed(s24);
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          res_val_q <= 20'((rsc > Lim) ? Lim : rsc);
          res_ovf_q <= ovf_q;
          res_v_q   <= 1'b1;
          total_q   <= '0;
          ovf_q     <= 1'b0;
          state_q   <= S_OUT;
        end
        S_OUT: if (res_ready_i) begin
          res_v_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pix_ready_o = (state_q == S_RD);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_v_q;
  assign res_o = '{entropy_value: res_val_q, count_overflow: res_ovf_q, done_res: 1'b1};
endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CountBits = 24;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned WatchLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic pix_valid_i = 1'b0;
  logic pix_ready_o;
  ihe_pkg::pix_t pix_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  ihe_pkg::res_t res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  always #10 clk_i = ~clk_i;

  image_histogram_entropy_top #(.COUNT_BITS(CountBits), .FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni, .pix_valid_i, .pix_ready_o, .pix_i,
    .res_valid_o, .res_ready_i, .res_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // shadow of the block state
  logic [CountBits-1:0] hist_bins [ihe_pkg::BinCount];
  logic [CountBits-1:0] pix_count;
  logic                 sat_flag;
  logic                 gray_mode_color;
  ihe_pkg::res_t        entropy_queue [$];
  int                   mismatches = 0;
  bit                   idle_on;
  int                   quiet_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  function automatic longint log2_fixed(input longint unsigned q);
    int ex;
    longint unsigned t, m, fr;
    ex = 0;
    t = q;
    fr = 0;
    while (t > 1) begin
      t >>= 1;
      ex++;
    end
    m = q << (30 - ex);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        fr |= 64'd1 << (23 - i);
      end
    end
    return longint'(ex - 24) * 64'sd16777216 + longint'(fr);
  endfunction

  function automatic logic [19:0] image_entropy();
    longint unsigned n, p, q, s24, prod, r, lim;
    longint s;
    n = pix_count;
    s = 0;
    if (n == 0) n = 1;
    for (int i = 0; i < ihe_pkg::BinCount; i++) begin
      p = ((longint'(hist_bins[i]) << 24) + (n >> 1)) / n;
      q = p + ihe_pkg::EpsQ24;
      s -= longint'(q) * log2_fixed(q);
    end
    if (s < 0) s = 0;
    s24 = (longint'(s) + (64'd1 << 23)) >> 24;
    prod = s24 * ihe_pkg::Ln2Q24;
    r = (prod + (64'd1 << (47 - FracBits))) >> (48 - FracBits);
    lim = (64'd1 << (FracBits + 4)) - 1;
    if (r > lim) r = lim;
    return r[19:0];
  endfunction

  function automatic void clear_image();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    pix_count = '0;
    sat_flag = 1'b0;
  endfunction

  // count one accepted pixel and queue the entropy on the last one
  function automatic void predict_pixel(input ihe_pkg::pix_t px);
    logic [31:0] g;
    ihe_pkg::res_t e;
    if (gray_mode_color)
      g = (32'(ihe_pkg::WeightB) * px.chan_blue + 32'(ihe_pkg::WeightG) * px.chan_green
           + 32'(ihe_pkg::WeightR) * px.chan_red + 32'(ihe_pkg::GrayRnd)) >> 14;
    else
      g = 32'(px.chan_blue);
    if (pix_count == {CountBits{1'b1}}) sat_flag = 1'b1;
    else begin
      pix_count++;
      hist_bins[g[7:0]]++;
    end
    if (px.last_pixel) begin
      e.entropy_value = image_entropy();
      e.count_overflow = sat_flag;
      e.done_res = 1'b1;
      entropy_queue = {entropy_queue, e};
      clear_image();
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    ihe_pkg::res_t want;
    if (rst_ni) begin
      if ((pix_valid_i && pix_ready_o) || (res_valid_o && res_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (res_valid_o && res_ready_i) begin
        if (entropy_queue.size() == 0) report("unexpected result", res_o, 0);
        else begin
          want = entropy_queue.pop_front();
          if (res_o.entropy_value !== want.entropy_value)
            report("entropy_value", res_o.entropy_value, want.entropy_value);
          if (res_o.count_overflow !== want.count_overflow)
            report("count_overflow", res_o.count_overflow, want.count_overflow);
          if (res_o.done_res !== want.done_res)
            report("done_res", res_o.done_res, want.done_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk_i) begin
    if (idle_on && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 4)) begin
        res_ready_i <= 1'b0;
        @(negedge clk_i);
      end
    res_ready_i <= 1'b1;
  end

  // valid stays up between back-to-back pixels; a gap or drain() drops it
  task automatic send_pixel(input logic [7:0] b, g, r, input logic last);
    ihe_pkg::pix_t px;
    px = '{chan_blue: b, chan_green: g, chan_red: r, last_pixel: last};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    pix_valid_i <= 1'b1;
    pix_i <= px;
    @(posedge clk_i);
    while (!pix_ready_o) @(posedge clk_i);
    predict_pixel(px);
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_valid_i <= 1'b0;
    while (entropy_queue.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gray_mode_color = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // extremes of each channel, single-pixel images, all-same and all-distinct
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'hff, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'hff, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'hff, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h55, 1'b0);
    send_pixel(8'haa, 8'h55, 8'haa, 1'b1);
    write_mode(1'b0);
    send_pixel(8'd0, 8'hff, 8'hff, 1'b0);
    send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h12, 8'h34, 1'b0);
    send_pixel(8'h01, 8'h55, 8'haa, 1'b1);
    for (int i = 0; i < 8; i++) send_pixel(8'h7f, 8'(i), 8'(~i), i == 7);
  endtask

  // random images, mostly short, a few long with a wide histogram
  task automatic test_random_images(input int pixels);
    int left, len;
    left = pixels;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(60, 250))
                                        : int'($urandom_range(1, 20));
      if (len > left) len = left;
      for (int i = 0; i < len; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == len - 1);
      left -= len;
    end
  endtask

  task automatic test_narrow_images(input int images);
    logic [7:0] base;
    for (int k = 0; k < images; k++) begin
      base = 8'($urandom);
      for (int i = 0; i < 12; i++)
        send_pixel(base + 8'($urandom_range(0, 2)), base, base, i == 11);
    end
  endtask

  initial begin
    clear_image();
    gray_mode_color = 1'b1;
    idle_on = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_mode(1'b1);
    test_random_images(450);
    test_narrow_images(10);
    write_mode(1'b0);
    test_random_images(400);
    test_narrow_images(10);
    write_mode(1'b1);
    idle_on = 1'b0;
    test_random_images(350);
    drain();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
